// ===== hw/rtl/dhwp_pkg.sv =====
// ----------------------------------------------------------------------------
// Digitizer hit word parser package
// Shared constants, payload types, control types and state codes.
// ----------------------------------------------------------------------------
package dhwp_pkg;

  localparam int MAX_HITS  = 16;
  localparam int HIT_IDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int CNT_W     = $clog2(MAX_HITS + 1);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HITS);

  localparam logic [3:0] NIB_HEADER  = 4'h8;
  localparam logic [3:0] NIB_NINE    = 4'h9;
  localparam logic [3:0] NIB_A       = 4'hA;
  localparam logic [3:0] NIB_B       = 4'hB;
  localparam logic [3:0] NIB_TRAILER = 4'hE;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] event_serial;
    logic [31:0] event_time;
    logic        bank_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] channel_address;
    logic [2:0]  card_type;
    logic [41:0] hit_time;
    logic [13:0] integration;
    logic [25:0] charge;
    logic [17:0] cfd_time;
    logic [31:0] serial_out;
    logic [31:0] hit_index;
    logic [31:0] time_out;
    logic        overflow;
    logic        last_of_group;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic accept_en;
    logic drain_step;
  } cmd_t;

  typedef struct packed {
    logic close_req;
    logic entry_last;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/dhwp_in_if.sv =====
// ----------------------------------------------------------------------------
// Word input channel
// Valid/ready channel carrying one bank word with its event context.
// ----------------------------------------------------------------------------
interface dhwp_in_if
  import dhwp_pkg::*;
  ;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== hw/rtl/dhwp_out_if.sv =====
// ----------------------------------------------------------------------------
// Hit output channel
// Valid/ready channel carrying one decoded hit.
// ----------------------------------------------------------------------------
interface dhwp_out_if
  import dhwp_pkg::*;
  ;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== hw/rtl/dhwp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Parser controller
// Switches between taking words and draining the buffered hits of a trailer.
// ----------------------------------------------------------------------------
module dhwp_ctrl
  import dhwp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.accept_en  = 1'b0;
    cmd.drain_step = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.accept_en = 1'b1;
        if (in_valid && status.close_req) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.out_free) begin
          cmd.drain_step = 1'b1;
          if (status.entry_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dhwp_datapath.sv =====
// ----------------------------------------------------------------------------
// Parser datapath
// Word history, hit store, trailer bookkeeping and the output register.
// ----------------------------------------------------------------------------
module dhwp_datapath
  import dhwp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [31:0] prior_one;
  logic [31:0] prior_two;
  logic [1:0]  bank_pos;
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] hit_count_next;
  logic        ovf_seen;
  logic        ovf_seen_next;
  logic [31:0] group_b;
  logic [31:0] group_b_next;
  logic [31:0] last_good_b;
  logic [31:0] cur_serial;
  logic [31:0] idx_cnt;

  logic [15:0] hdr_addr [MAX_HITS];
  logic [2:0]  hdr_card [MAX_HITS];
  logic [27:0] a_low [MAX_HITS];
  logic [30:0] height [MAX_HITS];
  logic [26:0] cfd [MAX_HITS];
  logic [MAX_HITS-1:0] nine_ok;
  logic [MAX_HITS-1:0] a_ok;

  logic [CNT_W-1:0] drain_cnt;
  logic [CNT_W-1:0] drain_i;
  logic        drain_b_ok;
  logic [13:0] drain_b_low;
  logic [31:0] drain_serial;
  logic [31:0] drain_time;
  logic        drain_ovf;

  logic        accept;
  logic [3:0]  nib;
  logic [CNT_W-1:0] hc_e;
  logic        ovf_e;
  logic [31:0] group_b_e;
  logic [31:0] prior_one_e;
  logic [31:0] prior_two_e;
  logic [1:0]  pos_e;
  logic [HIT_IDX_W-1:0] k_new;
  logic [HIT_IDX_W-1:0] k_top;
  logic        raw_ok;
  logic        is_header;
  logic        is_close;
  logic [31:0] b_sel;
  logic [HIT_IDX_W-1:0] rd;
  logic        good_i;
  logic [MAX_HITS-1:0] beyond;
  logic [31:0] new_idx;

  assign accept    = in_valid && cmd.accept_en;
  assign nib       = in_item.word[31:28];
  assign hc_e      = in_item.bank_start ? '0 : hit_count;
  assign ovf_e     = in_item.bank_start ? 1'b0 : ovf_seen;
  assign group_b_e = in_item.bank_start ? ALL_ONES : group_b;
  assign prior_one_e = in_item.bank_start ? 32'd0 : prior_one;
  assign prior_two_e = in_item.bank_start ? 32'd0 : prior_two;
  assign pos_e     = in_item.bank_start ? 2'd0 : bank_pos;
  assign k_new     = hc_e[HIT_IDX_W-1:0];
  assign k_top     = HIT_IDX_W'(hc_e - 1'b1);
  assign is_header = (nib == NIB_HEADER);
  assign is_close  = (nib == NIB_TRAILER) && (hc_e != '0);
  assign raw_ok    = (hc_e != '0) && !ovf_e && (pos_e == 2'd3) && (is_header || is_close);
  assign b_sel     = (group_b_e == ALL_ONES) ? last_good_b : group_b_e;

  always_comb begin
    hit_count_next = hc_e;
    ovf_seen_next  = ovf_e;
    group_b_next   = group_b_e;
    if (is_header) begin
      group_b_next = ALL_ONES;
      if (hc_e >= MAX_CNT) begin
        ovf_seen_next = 1'b1;
      end else begin
        hit_count_next = CNT_W'(hc_e + 1'b1);
      end
    end else if (hc_e != '0) begin
      case (nib)
        NIB_B: begin
          group_b_next = in_item.word;
        end
        NIB_TRAILER: begin
          hit_count_next = '0;
          ovf_seen_next  = 1'b0;
          group_b_next   = ALL_ONES;
        end
        default: begin
        end
      endcase
    end
  end

  assign rd     = drain_i[HIT_IDX_W-1:0];
  assign good_i = drain_b_ok && nine_ok[rd] && a_ok[rd];

  always_comb begin
    for (int j = 0; j < MAX_HITS; j++) begin
      beyond[j] = (CNT_W'(j) > drain_i) && (CNT_W'(j) < drain_cnt) &&
                  nine_ok[j] && a_ok[j];
    end
  end

  assign new_idx = (drain_serial != cur_serial) ? 32'd0 : idx_cnt;

  assign status.close_req  = is_close;
  assign status.entry_last = (drain_i == CNT_W'(drain_cnt - 1'b1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_one   <= '0;
      prior_two   <= '0;
      bank_pos    <= '0;
      hit_count   <= '0;
      ovf_seen    <= 1'b0;
      group_b     <= ALL_ONES;
      last_good_b <= ALL_ONES;
      cur_serial  <= '0;
      idx_cnt     <= '0;
      out_valid   <= 1'b0;
      drain_i     <= '0;
      drain_cnt   <= '0;
    end else begin
      if (accept) begin
        hit_count <= hit_count_next;
        ovf_seen  <= ovf_seen_next;
        group_b   <= group_b_next;
        if (raw_ok) begin
          height[k_top] <= prior_two_e[31] ? 31'd0 : prior_two_e[30:0];
          cfd[k_top]    <= prior_one_e[31] ? 27'd0 :
                           {prior_one_e[30:22], prior_one_e[17:0]};
        end
        if (is_header) begin
          if (hc_e < MAX_CNT) begin
            hdr_addr[k_new] <= in_item.word[19:4];
            hdr_card[k_new] <= in_item.word[27:25];
            nine_ok[k_new]  <= 1'b0;
            a_ok[k_new]     <= 1'b0;
            height[k_new]   <= '1;
            cfd[k_new]      <= '1;
          end
        end else if (hc_e != '0) begin
          case (nib)
            NIB_NINE: begin
              if (!ovf_e) begin
                nine_ok[k_top] <= 1'b1;
              end
            end
            NIB_A: begin
              if (!ovf_e) begin
                a_ok[k_top]  <= 1'b1;
                a_low[k_top] <= in_item.word[27:0];
              end
            end
            NIB_TRAILER: begin
              last_good_b  <= b_sel;
              drain_b_ok   <= (b_sel[31:28] == NIB_B);
              drain_b_low  <= b_sel[13:0];
              drain_serial <= in_item.event_serial;
              drain_time   <= in_item.event_time;
              drain_ovf    <= ovf_e;
              drain_cnt    <= hc_e;
              drain_i      <= '0;
            end
            default: begin
            end
          endcase
        end
        prior_two <= prior_one_e;
        prior_one <= in_item.word;
        bank_pos  <= (pos_e == 2'd3) ? 2'd3 : pos_e + 2'd1;
      end

      if (cmd.drain_step) begin
        drain_i <= CNT_W'(drain_i + 1'b1);
        if (good_i) begin
          out_valid  <= 1'b1;
          cur_serial <= drain_serial;
          idx_cnt    <= new_idx + 32'd1;
          out_item.channel_address <= hdr_addr[rd];
          out_item.card_type       <= hdr_card[rd];
          out_item.hit_time        <= {drain_b_low, a_low[rd]};
          out_item.integration     <= {height[rd][30:26], cfd[rd][26:18]};
          out_item.charge          <= height[rd][25:0];
          out_item.cfd_time        <= cfd[rd][17:0];
          out_item.serial_out      <= drain_serial;
          out_item.hit_index       <= new_idx;
          out_item.time_out        <= drain_time;
          out_item.overflow        <= drain_ovf;
          out_item.last_of_group   <= (beyond == '0);
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/digitizer_hit_word_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Digitizer hit word parser
// Classifies digitizer words, buffers hits and emits the good ones at a
// trailer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     transaction
//  words    in   valid/ready   one bank word with event serial and time
//  hits     out  valid/ready   one decoded hit
//
// One word is taken in every cycle while the controller is idle.
// A trailer that closes a group of N buffered hits holds the input until
// the hit store has been read, one entry a cycle while the output register
// is not stalled.
// Reset is synchronous and clears history, counters and the hit group.
// ----------------------------------------------------------------------------
module digitizer_hit_word_parser_unit
  import dhwp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  dhwp_in_if.sink    words,
  dhwp_out_if.source hits
);

  cmd_t    cmd;
  status_t status;

  assign words.ready = cmd.accept_en;

  dhwp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (words.valid),
    .status   (status),
    .cmd      (cmd)
  );

  dhwp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (words.valid),
    .in_item   (words.item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (hits.valid),
    .out_ready (hits.ready),
    .out_item  (hits.item)
  );

endmodule
